/* rtl/core/sbp_pkg.sv */
// Package for the six-button pad TH multiplexer.
// Holds item types, operation and register codes, button indexes, the note
// map and the line pattern functions. Depends on nothing.
package sbp_pkg;

   localparam int NUM_BUTTONS = 12;
   localparam int NUM_LINES   = 6;

   // Operation codes of an input item.
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_NOTE    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;
   localparam logic [1:0] OP_NONE    = 2'd3;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_KIND   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAIT_LIMIT = 8'd1;

   localparam logic [15:0] WAIT_LIMIT_RESET = 16'd1000;

   // Button bit positions.
   localparam logic [3:0] KEY_UP    = 4'd0;
   localparam logic [3:0] KEY_DOWN  = 4'd1;
   localparam logic [3:0] KEY_LEFT  = 4'd2;
   localparam logic [3:0] KEY_RIGHT = 4'd3;
   localparam logic [3:0] KEY_A     = 4'd4;
   localparam logic [3:0] KEY_B     = 4'd5;
   localparam logic [3:0] KEY_C     = 4'd6;
   localparam logic [3:0] KEY_START = 4'd7;
   localparam logic [3:0] KEY_X     = 4'd8;
   localparam logic [3:0] KEY_Y     = 4'd9;
   localparam logic [3:0] KEY_Z     = 4'd10;
   localparam logic [3:0] KEY_MODE  = 4'd11;

   localparam logic [2:0] STEP_IDLE = 3'd1;
   localparam logic [2:0] STEP_LAST = 3'd7;

   typedef struct packed {
      logic [1:0] op;
      logic       th_level;
      logic [6:0] note;
      logic       pressed;
   } req_type;

   typedef struct packed {
      logic [5:0] lines_active;
      logic [2:0] shown_step_out;
      logic       busy_res;
      logic       timed_out;
   } rsp_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] idx;
   } note_map_type;

   function automatic note_map_type note_button(input logic [6:0] note);
      note_map_type m;
      m.hit = 1'b1;
      unique case (note)
         7'd1:    m.idx = KEY_UP;
         7'd2:    m.idx = KEY_DOWN;
         7'd3:    m.idx = KEY_LEFT;
         7'd4:    m.idx = KEY_RIGHT;
         7'd6:    m.idx = KEY_A;
         7'd7:    m.idx = KEY_B;
         7'd9:    m.idx = KEY_C;
         7'd10:   m.idx = KEY_START;
         7'd11:   m.idx = KEY_X;
         7'd12:   m.idx = KEY_Y;
         7'd13:   m.idx = KEY_Z;
         7'd14:   m.idx = KEY_MODE;
         default: begin
            m.hit = 1'b0;
            m.idx = KEY_UP;
         end
      endcase
      return m;
   endfunction

   // Lines pulled low for a given step; bit 0 is D0.
   function automatic logic [NUM_LINES-1:0] step_pattern(input logic [2:0] step,
                                                         input logic [NUM_BUTTONS-1:0] b);
      logic [NUM_LINES-1:0] p;
      unique case (step)
         3'd0, 3'd2: p = {b[KEY_START], b[KEY_A], 1'b1, 1'b1, b[KEY_DOWN], b[KEY_UP]};
         3'd4:       p = {b[KEY_START], b[KEY_A], 4'b1111};
         3'd5:       p = {2'b00, b[KEY_MODE], b[KEY_X], b[KEY_Y], b[KEY_Z]};
         3'd6:       p = {b[KEY_START], b[KEY_A], 4'b0000};
         default:    p = {b[KEY_C], b[KEY_B], b[KEY_RIGHT], b[KEY_LEFT],
                          b[KEY_DOWN], b[KEY_UP]};
      endcase
      return p;
   endfunction

   function automatic logic [NUM_LINES-1:0] simple_pattern(input logic [NUM_BUTTONS-1:0] b);
      return {b[KEY_B], b[KEY_A], b[KEY_RIGHT], b[KEY_LEFT], b[KEY_DOWN], b[KEY_UP]};
   endfunction

endpackage

/* rtl/core/sbp_state.sv */
// Pad state, configuration registers and per-item next-state logic.
// Produces the result of an accepted item in the same cycle. Uses sbp_pkg.
module sbp_state
   import sbp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_accept,
   input  req_type                item,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_wdata,
   output rsp_type                result
);

   logic                   pad_kind_ff, pad_kind_in;
   logic [15:0]            wait_limit_ff, wait_limit_in;
   logic [NUM_BUTTONS-1:0] buttons_ff, buttons_in;
   logic [2:0]             shown_step_ff, shown_step_in;
   logic                   in_seq_ff, in_seq_in;
   logic [15:0]            wait_count_ff, wait_count_in;
   logic                   last_th_ff, last_th_in;

   logic [NUM_BUTTONS-1:0] item_buttons;
   logic [2:0]             item_step;
   logic                   item_in_seq;
   logic [15:0]            item_wait;
   logic                   item_last_th;
   logic                   aborted;
   logic [15:0]            limit;
   logic [15:0]            wait_inc;
   logic [2:0]             step_inc;
   note_map_type           nmap;

   assign limit    = (wait_limit_ff == 16'd0) ? 16'd1 : wait_limit_ff;
   assign wait_inc = wait_count_ff + 16'd1;
   assign step_inc = shown_step_ff + 3'd1;
   assign nmap     = note_button(item.note);

   // State after the item, before any configuration write.
   always_comb begin
      item_buttons = buttons_ff;
      item_step    = shown_step_ff;
      item_in_seq  = in_seq_ff;
      item_wait    = wait_count_ff;
      item_last_th = last_th_ff;
      aborted      = 1'b0;
      unique case (item.op)
         OP_TICK: begin
            if (pad_kind_ff) begin
               if (in_seq_ff) begin
                  // Even steps wait for TH high, odd steps for TH low.
                  if (item.th_level == ~shown_step_ff[0]) begin
                     item_wait = 16'd0;
                     if (step_inc == STEP_LAST) begin
                        item_step   = STEP_IDLE;
                        item_in_seq = 1'b0;
                     end else begin
                        item_step = step_inc;
                     end
                  end else if (wait_inc >= limit) begin
                     item_wait   = 16'd0;
                     item_step   = STEP_IDLE;
                     item_in_seq = 1'b0;
                     aborted     = 1'b1;
                  end else begin
                     item_wait = wait_inc;
                  end
               end else if (last_th_ff && !item.th_level) begin
                  item_in_seq = 1'b1;
                  item_step   = 3'd0;
                  item_wait   = 16'd0;
               end
            end
            item_last_th = item.th_level;
         end
         OP_NOTE: begin
            if (nmap.hit) begin
               item_buttons[nmap.idx] = item.pressed;
               if (pad_kind_ff && !in_seq_ff) begin
                  item_step = {2'b00, last_th_ff};
               end
            end
         end
         OP_RELEASE: begin
            item_buttons = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.lines_active   = pad_kind_ff ? step_pattern(item_step, item_buttons)
                                          : simple_pattern(item_buttons);
      result.shown_step_out = pad_kind_ff ? item_step : 3'd0;
      result.busy_res       = pad_kind_ff & item_in_seq;
      result.timed_out      = aborted;
   end

   always_comb begin
      pad_kind_in   = pad_kind_ff;
      wait_limit_in = wait_limit_ff;
      buttons_in    = buttons_ff;
      shown_step_in = shown_step_ff;
      in_seq_in     = in_seq_ff;
      wait_count_in = wait_count_ff;
      last_th_in    = last_th_ff;
      if (item_accept) begin
         buttons_in    = item_buttons;
         shown_step_in = item_step;
         in_seq_in     = item_in_seq;
         wait_count_in = item_wait;
         last_th_in    = item_last_th;
      end
      if (csr_write) begin
         if (csr_index == CSR_PAD_KIND) begin
            // Writing the pad kind drops all buttons and any sequence.
            pad_kind_in   = csr_wdata[0];
            buttons_in    = '0;
            in_seq_in     = 1'b0;
            wait_count_in = 16'd0;
            shown_step_in = {2'b00, last_th_ff};
         end else if (csr_index == CSR_WAIT_LIMIT) begin
            wait_limit_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_kind_ff   <= 1'b0;
         wait_limit_ff <= WAIT_LIMIT_RESET;
         buttons_ff    <= '0;
         shown_step_ff <= STEP_IDLE;
         in_seq_ff     <= 1'b0;
         wait_count_ff <= 16'd0;
         last_th_ff    <= 1'b0;
      end else begin
         pad_kind_ff   <= pad_kind_in;
         wait_limit_ff <= wait_limit_in;
         buttons_ff    <= buttons_in;
         shown_step_ff <= shown_step_in;
         in_seq_ff     <= in_seq_in;
         wait_count_ff <= wait_count_in;
         last_th_ff    <= last_th_in;
      end
   end

endmodule

/* rtl/core/sbp_outbuf.sv */
// Result register with a skid entry so an item can be taken while the
// previous result is stalled. Uses sbp_pkg.
module sbp_outbuf
   import sbp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    can_push,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    main_valid_ff, main_valid_in;
   rsp_type main_data_ff, main_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   assign pop       = main_valid_ff & rsp_ready;
   assign can_push  = ~skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

/* rtl/core/six_button_pad_th_multiplexer_top.sv */
// Six-button pad TH multiplexer, top level.
// Results are registered; one item per cycle while input ready is high.
// While a result is stalled the one-entry skid takes one more item, then input
// ready drops until the stalled result is taken.
// Reset is synchronous, active high: buttons released, idle step 1, simple mode.
// Configuration writes are always ready and take effect at the next edge.
module six_button_pad_th_multiplexer_top
   import sbp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_wdata
);

   logic    item_accept;
   rsp_type result;

   assign csr_ready   = 1'b1;
   assign item_accept = req_valid & req_ready;

   sbp_state u_state (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .item        (req_data),
      .csr_write   (csr_valid & csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .result      (result)
   );

   sbp_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (item_accept),
      .push_data (result),
      .can_push  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
